/* rtl/core/brms_pkg.sv */
// ----------------------------------------------------------------------------
// brms_pkg: shared types and codes for the byte ring with mark search
// command, status and state encodings, register map and reset values
// ----------------------------------------------------------------------------
package brms_pkg;

  typedef enum logic [1:0] {
    CMD_PUSH    = 2'd0,
    CMD_TO_MARK = 2'd1,
    CMD_ALL     = 2'd2,
    CMD_DISCARD = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_DATA     = 2'd0,
    STAT_NONE     = 2'd1,
    STAT_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT_RD,
    ST_EMIT_WR,
    ST_RESP
  } state_t;

  // register index, taken from paddr[2]
  localparam logic REG_MARK_LENGTH = 1'b0;
  localparam logic REG_MARK_BYTES  = 1'b1;

  localparam logic [2:0]  MARK_LENGTH_RST = 3'd2;
  localparam logic [31:0] MARK_BYTES_RST  = 32'h0000_0A0D;

endpackage

/* rtl/core/brms_ram.sv */
// ----------------------------------------------------------------------------
// brms_ram: generic single-write, single-read RAM
// one write port, one read port with registered read data held between reads
// ----------------------------------------------------------------------------
module brms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/byte_ring_with_mark_search.sv */
// ----------------------------------------------------------------------------
// byte_ring_with_mark_search: circular byte store with delimiter extraction
// push, consume-to-mark, consume-all and discard over a DEPTH-byte ring
// ----------------------------------------------------------------------------
// Sequencing: a push or a discard completes in the idle state that takes it,
// and the block stays idle and ready for another request; a push into a full
// store first hands out its overflow status from the response state. Consume-
// all hands out the N stored bytes one at a time, as the single RAM read port
// fetches one byte and the result register then takes it. A consume-to-mark
// first walks the store through the same read port, one byte a cycle, feeding
// a window of the last MAX_MARK bytes into one shared mark comparator, until
// the mark is found or every stored byte has been seen (a miss); then it hands
// out each byte up to the end of the mark in the same way. A stalled output
// holds a run in place. The request channel is stalled for the whole run of a
// consume command; the store itself needs no clearing pass after reset.
// ----------------------------------------------------------------------------
module byte_ring_with_mark_search #(
  parameter int DEPTH    = 64,
  parameter int MAX_MARK = 4
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request channel
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  cmd,
  input  logic [7:0]  data_in,
  input  logic [6:0]  count,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  data_out,
  output logic        last,
  output logic [1:0]  status
);

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int SUM_W  = PTR_W + 2;
  localparam int CMP_W  = (FILL_W > 3) ? FILL_W : 3;

  // configuration registers
  logic [2:0]  mark_length;
  logic [31:0] mark_bytes;

  // ring pointers and fill level
  logic [PTR_W-1:0]  rp;
  logic [PTR_W-1:0]  wp;
  logic [FILL_W-1:0] fill;

  // sequencer
  brms_pkg::state_t  state;
  brms_pkg::state_t  state_next;
  logic [PTR_W-1:0]  walk_ptr;      // next store address to read
  logic [FILL_W-1:0] issue_cnt;     // reads issued during the scan
  logic [FILL_W-1:0] seen_cnt;      // bytes already through the window
  logic              rd_pend;       // read data arrives this cycle
  logic [FILL_W-1:0] total;         // bytes to hand out in this run
  logic [FILL_W-1:0] idx;           // bytes handed out so far
  logic [MAX_MARK-1:0][7:0] window; // newest byte at position 0
  brms_pkg::status_t resp_status;

  // result register
  logic              out_valid;
  logic [7:0]        out_data;
  logic              out_last;
  brms_pkg::status_t out_status;

  // store
  logic              ram_wr_en;
  logic              ram_rd_en;
  logic [7:0]        ram_rd_data;

  // control decoded from the state
  brms_pkg::cmd_t    cmd_code;
  logic              item_acc;
  logic              slot_free;
  logic              full;
  logic              issue;
  logic              scan_hit;
  logic              scan_miss;
  logic              emit_fire;
  logic              emit_final;
  logic              resp_fire;
  logic              cfg_wr;

  // walk pointer step with wrap
  logic [PTR_W-1:0]  walk_inc;
  logic [PTR_W-1:0]  wp_inc;

  // discard arithmetic
  logic [FILL_W-1:0] disc_n;
  logic [SUM_W-1:0]  disc_sum;
  logic [PTR_W-1:0]  disc_ptr;

  // mark comparator
  logic [2:0]               mlen;
  logic [MAX_MARK-1:0][7:0] window_next;
  logic [MAX_MARK-1:0][7:0] mark_aligned;
  logic [MAX_MARK-1:0]      mark_mask;
  logic [FILL_W-1:0]        seen_next;
  logic                     window_match;

  assign cmd_code  = brms_pkg::cmd_t'(cmd);
  assign item_acc  = item_valid && (state == brms_pkg::ST_IDLE);
  assign slot_free = !out_valid || !result_stall;
  assign full      = (fill == FILL_W'(DEPTH));
  assign cfg_wr    = psel && penable && pwrite && pready;

  assign walk_inc = (walk_ptr == PTR_W'(DEPTH - 1)) ? '0 : walk_ptr + PTR_W'(1);
  assign wp_inc   = (wp == PTR_W'(DEPTH - 1)) ? '0 : wp + PTR_W'(1);

  // discard count clamped to the fill level, pointer wrap by one subtract
  assign disc_n   = (count > 7'(fill)) ? fill : FILL_W'(count);
  assign disc_sum = SUM_W'(rp) + SUM_W'(disc_n);
  assign disc_ptr = (disc_sum >= SUM_W'(DEPTH)) ? PTR_W'(disc_sum - SUM_W'(DEPTH))
                                                : PTR_W'(disc_sum);

  // effective mark length: zero counts as one, capped at MAX_MARK
  always_comb begin
    if (mark_length == 3'd0) begin
      mlen = 3'd1;
    end else if (int'(mark_length) > MAX_MARK) begin
      mlen = 3'(MAX_MARK);
    end else begin
      mlen = mark_length;
    end
  end

  // mark bytes lined up with the window: mark byte j sits at position mlen-1-j,
  // mark bytes past the 32-bit register read as zero
  always_comb begin
    mark_aligned = '0;
    mark_mask    = '0;
    for (int p = 0; p < MAX_MARK; p++) begin
      mark_mask[p] = (p < int'(mlen));
      for (int j = 0; j < MAX_MARK; j++) begin
        if ((j + p + 1) == int'(mlen)) begin
          mark_aligned[p] = 8'(mark_bytes >> (8 * j));
        end
      end
    end
  end

  // shared comparator on the window after the incoming byte is shifted in
  always_comb begin
    window_match = 1'b1;
    for (int p = 0; p < MAX_MARK; p++) begin
      window_next[p] = (p == 0) ? ram_rd_data : window[(p == 0) ? 0 : p - 1];
      if (mark_mask[p] && (window_next[p] != mark_aligned[p])) begin
        window_match = 1'b0;
      end
    end
  end

  assign seen_next = seen_cnt + FILL_W'(1);

  assign issue      = (state == brms_pkg::ST_SCAN) && (issue_cnt < fill);
  assign scan_hit   = (state == brms_pkg::ST_SCAN) && rd_pend && window_match &&
                      (CMP_W'(seen_next) >= CMP_W'(mlen));
  assign scan_miss  = (state == brms_pkg::ST_SCAN) && !rd_pend && !(issue_cnt < fill);
  assign emit_fire  = (state == brms_pkg::ST_EMIT_WR) && slot_free;
  assign emit_final = ((idx + FILL_W'(1)) == total);
  assign resp_fire  = (state == brms_pkg::ST_RESP) && slot_free;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      brms_pkg::ST_IDLE: begin
        if (item_valid) begin
          case (cmd_code)
            brms_pkg::CMD_PUSH:    state_next = full ? brms_pkg::ST_RESP : brms_pkg::ST_IDLE;
            brms_pkg::CMD_TO_MARK: state_next = brms_pkg::ST_SCAN;
            brms_pkg::CMD_ALL: begin
              state_next = (fill == '0) ? brms_pkg::ST_RESP : brms_pkg::ST_EMIT_RD;
            end
            brms_pkg::CMD_DISCARD: state_next = brms_pkg::ST_IDLE;
            default:               state_next = brms_pkg::ST_IDLE;
          endcase
        end
      end
      brms_pkg::ST_SCAN: begin
        if (scan_hit) begin
          state_next = brms_pkg::ST_EMIT_RD;
        end else if (scan_miss) begin
          state_next = brms_pkg::ST_RESP;
        end
      end
      brms_pkg::ST_EMIT_RD: state_next = brms_pkg::ST_EMIT_WR;
      brms_pkg::ST_EMIT_WR: begin
        if (slot_free) begin
          state_next = emit_final ? brms_pkg::ST_IDLE : brms_pkg::ST_EMIT_RD;
        end
      end
      brms_pkg::ST_RESP: begin
        if (slot_free) begin
          state_next = brms_pkg::ST_IDLE;
        end
      end
      default: state_next = brms_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    item_stall = (state != brms_pkg::ST_IDLE);
    ram_wr_en  = item_acc && (cmd_code == brms_pkg::CMD_PUSH) && !full;
    ram_rd_en  = issue || (state == brms_pkg::ST_EMIT_RD);
  end

  brms_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (wp),
    .wr_data (data_in),
    .rd_en   (ram_rd_en),
    .rd_addr (walk_ptr),
    .rd_data (ram_rd_data)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= brms_pkg::ST_IDLE;
      rp          <= '0;
      wp          <= '0;
      fill        <= '0;
      mark_length <= brms_pkg::MARK_LENGTH_RST;
      mark_bytes  <= brms_pkg::MARK_BYTES_RST;
      out_valid   <= 1'b0;
      rd_pend     <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= issue;

      if (cfg_wr) begin
        if (paddr[2] == brms_pkg::REG_MARK_BYTES) begin
          mark_bytes <= pwdata;
        end else begin
          mark_length <= pwdata[2:0];
        end
      end

      if (emit_fire || resp_fire) begin
        out_valid <= 1'b1;
      end else if (!result_stall) begin
        out_valid <= 1'b0;
      end

      // push and discard finish in the idle cycle that takes the request
      if (item_acc && (cmd_code == brms_pkg::CMD_PUSH) && !full) begin
        wp   <= wp_inc;
        fill <= fill + FILL_W'(1);
      end
      if (item_acc && (cmd_code == brms_pkg::CMD_DISCARD)) begin
        rp   <= disc_ptr;
        fill <= fill - disc_n;
      end

      // the consumed bytes leave the ring with the final one handed out
      if (emit_fire && emit_final) begin
        rp   <= walk_inc;
        fill <= fill - total;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      brms_pkg::ST_IDLE: begin
        if (item_acc) begin
          walk_ptr  <= rp;
          issue_cnt <= '0;
          seen_cnt  <= '0;
          idx       <= '0;
          total     <= fill;
          resp_status <= (cmd_code == brms_pkg::CMD_PUSH) ? brms_pkg::STAT_OVERFLOW
                                                          : brms_pkg::STAT_NONE;
        end
      end
      brms_pkg::ST_SCAN: begin
        if (issue) begin
          issue_cnt <= issue_cnt + FILL_W'(1);
        end
        if (rd_pend) begin
          window   <= window_next;
          seen_cnt <= seen_next;
        end
        // mark ends here: rewind and hand out everything up to it
        if (scan_hit) begin
          walk_ptr <= rp;
          idx      <= '0;
          total    <= seen_next;
        end else if (issue) begin
          walk_ptr <= walk_inc;
        end
      end
      brms_pkg::ST_EMIT_WR: begin
        if (slot_free) begin
          out_data   <= ram_rd_data;
          out_last   <= emit_final;
          out_status <= brms_pkg::STAT_DATA;
          walk_ptr   <= walk_inc;
          idx        <= idx + FILL_W'(1);
        end
      end
      brms_pkg::ST_RESP: begin
        if (slot_free) begin
          out_data   <= '0;
          out_last   <= 1'b1;
          out_status <= resp_status;
        end
      end
      default: begin
      end
    endcase
  end

  assign result_valid = out_valid;
  assign data_out     = out_data;
  assign last         = out_last;
  assign status       = out_status;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == brms_pkg::REG_MARK_BYTES) ? mark_bytes
                                                         : {29'd0, mark_length};

endmodule

/* rtl/core/brms_checker.sv */
// ----------------------------------------------------------------------------
// brms_checker: port-level checks for the byte ring with mark search
// watches the request and result channels, attached to the top level by bind
// ----------------------------------------------------------------------------
module brms_checker (
  input logic       clk,
  input logic       rst,
  input logic       item_valid,
  input logic       item_stall,
  input logic [1:0] cmd,
  input logic       result_valid,
  input logic       result_stall,
  input logic [7:0] data_out,
  input logic       last,
  input logic [1:0] status
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(data_out) &&
                                     $stable(last) && $stable(status))
    else $error("stalled result changed");

  // non-data results are single, empty and closing
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (status != brms_pkg::STAT_DATA) |-> last && (data_out == 8'd0))
    else $error("status result not closing or carries data");

  // consume requests always produce a run, so the request side stalls
  assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall &&
    ((cmd == brms_pkg::CMD_TO_MARK) || (cmd == brms_pkg::CMD_ALL)) |=> item_stall)
    else $error("consume request did not start a run");

  // no unused status code ever leaves the block
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (status == brms_pkg::STAT_DATA) || (status == brms_pkg::STAT_NONE) ||
                     (status == brms_pkg::STAT_OVERFLOW))
    else $error("undefined status code");

endmodule

bind byte_ring_with_mark_search brms_checker u_brms_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .cmd          (cmd),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .data_out     (data_out),
  .last         (last),
  .status       (status)
);

/* tb/sv/brms_result_check.sv */
// ----------------------------------------------------------------------------
// brms_result_check: result checker for the byte ring with mark search
// watches the config port and both channels, keeps its own copy of the ring
// and compares every result with the oldest outstanding one
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module brms_result_check
  import brms_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        item_valid,
  input  logic        item_stall,
  input  cmd_t        cmd,
  input  logic [7:0]  data_in,
  input  logic [6:0]  count,
  input  logic        result_valid,
  input  logic        result_stall,
  input  logic [7:0]  data_out,
  input  logic        last,
  input  logic [1:0]  status,
  output int          fail_count,
  output int          pending,
  output logic [6:0]  ring_fill,
  output logic [5:0]  ring_wr
);

  localparam int DEPTH    = 64;
  localparam int MAX_MARK = 4;

  typedef struct {
    logic [7:0] data;
    logic       last;
    status_t    status;
  } outcome_t;

  outcome_t    owed[$];
  logic [7:0]  ring_mem [DEPTH];
  int          rd_pos = 0;
  int          wr_pos = 0;
  int          fill = 0;
  logic [2:0]  mark_len = MARK_LENGTH_RST;
  logic [31:0] mark_val = MARK_BYTES_RST;
  int          misses = 0;

  task automatic owe(input logic [7:0] d, input logic l, input status_t s);
    outcome_t o;
    o.data   = d;
    o.last   = l;
    o.status = s;
    owed.push_back(o);
  endtask

  // hand out the k oldest bytes, last flag on the final one
  task automatic take_bytes(input int k);
    int i;
    for (i = 0; i < k; i++) begin
      owe(ring_mem[(rd_pos + i) % DEPTH], i == k - 1, STAT_DATA);
    end
    rd_pos = (rd_pos + k) % DEPTH;
    fill -= k;
  endtask

  task automatic ring_step(input cmd_t c, input logic [7:0] d, input logic [6:0] n);
    int eff, at, start, j;
    bit hit;
    case (c)
      CMD_PUSH: begin
        if (fill >= DEPTH) begin
          owe(8'h00, 1'b1, STAT_OVERFLOW);
        end else begin
          ring_mem[wr_pos] = d;
          wr_pos = (wr_pos + 1) % DEPTH;
          fill++;
        end
      end
      CMD_TO_MARK: begin
        eff = (mark_len == 0) ? 1 : (int'(mark_len) > MAX_MARK) ? MAX_MARK : int'(mark_len);
        at = -1;
        // first occurrence wins, the window may run over the wrap point
        for (start = 0; at < 0 && start + eff <= fill; start++) begin
          hit = 1'b1;
          for (j = 0; j < eff; j++) begin
            if (ring_mem[(rd_pos + start + j) % DEPTH] != mark_val[8*j +: 8]) hit = 1'b0;
          end
          if (hit) at = start;
        end
        if (at < 0) begin
          owe(8'h00, 1'b1, STAT_NONE);
        end else begin
          take_bytes(at + eff);
        end
      end
      CMD_ALL: begin
        if (fill == 0) begin
          owe(8'h00, 1'b1, STAT_NONE);
        end else begin
          take_bytes(fill);
        end
      end
      CMD_DISCARD: begin
        j = (int'(n) > fill) ? fill : int'(n);
        rd_pos = (rd_pos + j) % DEPTH;
        fill -= j;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      owed.delete();
      rd_pos   = 0;
      wr_pos   = 0;
      fill     = 0;
      mark_len = MARK_LENGTH_RST;
      mark_val = MARK_BYTES_RST;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_MARK_BYTES) begin
          mark_val = pwdata;
        end else begin
          mark_len = pwdata[2:0];
        end
      end
      if (item_valid && !item_stall) ring_step(cmd, data_in, count);
      if (result_valid && !result_stall) begin
        if (owed.size() == 0) begin
          misses++;
          if (misses <= 10)
            $display("%0t: unexpected result: data %02h last %0d status %0d",
                     $time, data_out, last, status);
        end else begin
          want = owed.pop_front();
          if (want.data !== data_out || want.last !== last || want.status !== status) begin
            misses++;
            if (misses <= 10)
              $display("%0t: mismatch: expected data %02h last %0d status %0d, got data %02h last %0d status %0d",
                       $time, want.data, want.last, want.status, data_out, last, status);
          end
        end
      end
    end
    pending    <= owed.size();
    ring_fill  <= 7'(fill);
    ring_wr    <= 6'(wr_pos);
    fail_count <= misses;
  end

endmodule

/* tb/sv/tb_byte_ring_with_mark_search.sv */
// ----------------------------------------------------------------------------
// tb_byte_ring_with_mark_search: testbench top for the byte ring
// directed corner requests, then line-shaped random traffic over several mark
// settings, with random idling, a long output hold-off and a full store
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_byte_ring_with_mark_search;
  import brms_pkg::*;

  localparam int DEPTH       = 64;
  localparam int MAX_MARK    = 4;
  localparam int PHASES      = 7;
  localparam int PER_PHASE   = 30;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        item_valid = 1'b0;
  logic        item_stall;
  cmd_t        cmd = CMD_PUSH;
  logic [7:0]  data_in = '0;
  logic [6:0]  count = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [7:0]  data_out;
  logic        last;
  logic [1:0]  status;

  // from the checker
  int          fail_count;
  int          pending;
  logic [6:0]  ring_fill;
  logic [5:0]  ring_wr;

  // traffic shaping
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_asked = 0;
  int          hold_done = 0;
  int          hold_left = 0;
  int          sent = 0;
  int          mark_eff = 2;
  logic [31:0] mark_val = MARK_BYTES_RST;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  byte_ring_with_mark_search dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .cmd          (cmd),
    .data_in      (data_in),
    .count        (count),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .data_out     (data_out),
    .last         (last),
    .status       (status)
  );

  brms_result_check ring_check (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .cmd          (cmd),
    .data_in      (data_in),
    .count        (count),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .data_out     (data_out),
    .last         (last),
    .status       (status),
    .fail_count   (fail_count),
    .pending      (pending),
    .ring_fill    (ring_fill),
    .ring_wr      (ring_wr)
  );

  // receiver: random stalls, or a long hold-off counted here once asked for
  always @(posedge clk) begin
    if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left    <= hold_left - 1;
    end else if (hold_asked != hold_done) begin
      result_stall <= 1'b1;
      hold_done    <= hold_asked;
      hold_left    <= HOLD_CYCLES;
    end else begin
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // offer one request, maybe after a random gap, and wait until it is taken
  task automatic send_req(input cmd_t c, input logic [7:0] d, input logic [6:0] n);
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    cmd        <= c;
    data_in    <= d;
    count      <= n;
    do @(posedge clk); while (item_stall);
    sent++;
  endtask

  // drop valid for a cycle so that the checker's view of the ring is current
  task automatic go_quiet();
    item_valid <= 1'b0;
    @(posedge clk);
  endtask

  // setup cycle, access cycle, then an idle wait before anything else
  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // random byte, often one of the mark bytes to make near misses
  function automatic logic [7:0] pick_byte();
    int k;
    k = $urandom_range(mark_eff - 1);
    if ($urandom_range(2) == 0) return mark_val[8*k +: 8];
    return 8'($urandom);
  endfunction

  // one text line: payload, the mark (sometimes only a prefix), a short tail,
  // then a consume-to-mark
  task automatic send_line();
    int n, s, k, i, upto, tail;
    n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
    if (mark_eff > 1 && $urandom_range(1) == 0) begin
      // size the payload so that the mark straddles the wrap point
      go_quiet();
      s = $urandom_range(mark_eff - 1, 1);
      k = (2 * DEPTH - s - int'(ring_wr)) % DEPTH;
      if (k <= 16 && int'(ring_fill) + k + mark_eff <= DEPTH) n = k;
    end
    repeat (n) send_req(CMD_PUSH, pick_byte(), 7'($urandom));
    upto = ($urandom_range(7) == 0) ? $urandom_range(mark_eff - 1) : mark_eff;
    for (i = 0; i < upto; i++) send_req(CMD_PUSH, mark_val[8*i +: 8], 7'($urandom));
    tail = ($urandom_range(3) == 0) ? $urandom_range(3) : 0;
    repeat (tail) send_req(CMD_PUSH, pick_byte(), 7'($urandom));
    send_req(CMD_TO_MARK, 8'($urandom), 7'($urandom));
  endtask

  // top the store up to full and push a few more into overflow
  task automatic fill_store();
    go_quiet();
    repeat (DEPTH - int'(ring_fill) + $urandom_range(3, 1))
      send_req(CMD_PUSH, pick_byte(), 7'($urandom));
  endtask

  initial begin
    int          ph, goal, r, len, k;
    logic [31:0] word;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed corners under the reset mark, carriage return then line feed
    send_req(CMD_ALL, 8'h00, 7'd0);        // empty store, no data
    send_req(CMD_TO_MARK, 8'h00, 7'd0);    // empty store, mark not found
    send_req(CMD_DISCARD, 8'h00, 7'd0);    // nothing to drop
    send_req(CMD_PUSH, 8'h0D, 7'd0);
    send_req(CMD_TO_MARK, 8'h00, 7'd0);    // fewer bytes than the mark is long
    send_req(CMD_PUSH, 8'h00, 7'd0);
    send_req(CMD_PUSH, 8'hFF, 7'd127);
    send_req(CMD_PUSH, 8'h0D, 7'd0);
    send_req(CMD_PUSH, 8'h0D, 7'd0);
    send_req(CMD_PUSH, 8'h0A, 7'd0);
    send_req(CMD_TO_MARK, 8'hFF, 7'd127);  // false start before the real mark
    send_req(CMD_PUSH, 8'h0A, 7'd0);
    send_req(CMD_PUSH, 8'h0D, 7'd0);
    send_req(CMD_TO_MARK, 8'h00, 7'd0);    // mark reversed, and a prefix at the end
    send_req(CMD_DISCARD, 8'h00, 7'd127);  // count clamped to the fill level
    send_req(CMD_PUSH, 8'h41, 7'd0);
    send_req(CMD_PUSH, 8'h0D, 7'd0);
    send_req(CMD_PUSH, 8'h0A, 7'd0);
    send_req(CMD_PUSH, 8'h42, 7'd0);
    send_req(CMD_DISCARD, 8'h00, 7'd1);
    send_req(CMD_TO_MARK, 8'h00, 7'd0);    // mark right at the read pointer
    send_req(CMD_PUSH, 8'h00, 7'd0);
    send_req(CMD_ALL, 8'h00, 7'd0);

    for (ph = 0; ph < PHASES; ph++) begin
      if (ph != 0) begin
        // let every result out and the block settle before a register write
        go_quiet();
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        case (ph)
          1:       begin len = 1; word = 32'h0000_0000; end
          2:       begin len = 4; word = 32'hFFFF_FFFF; end
          3:       begin len = 0; word = $urandom;      end  // taken as one byte
          4:       begin len = 7; word = 32'hAAAA_AAAA; end  // clamped, self-overlapping
          5:       begin len = 3; word = $urandom;      end
          default: begin len = 5; word = $urandom;      end
        endcase
        write_reg(REG_MARK_LENGTH, 32'(len));
        write_reg(REG_MARK_BYTES, word);
        mark_val = word;
        mark_eff = (len == 0) ? 1 : (len > MAX_MARK) ? MAX_MARK : len;
      end

      // idling mode for this phase
      case (ph % 4)
        0:       begin idle_pct = 0;  stall_pct <= 0;  end
        1:       begin idle_pct = 48; stall_pct <= 0;  end
        2:       begin idle_pct = 0;  stall_pct <= 48; end
        default: begin idle_pct = 8;  stall_pct <= 8;  end
      endcase

      if (ph == 2) begin
        // full store, then hold the output off while requests keep coming so
        // that the consume run backs up into the request channel
        fill_store();
        hold_asked <= hold_asked + 1;
        send_req(CMD_ALL, 8'($urandom), 7'($urandom));
        send_line();
        send_line();
      end

      goal = sent + PER_PHASE;
      while (sent < goal) begin
        r = $urandom_range(99);
        if (r < 62) begin
          send_line();
        end else if (r < 65) begin
          fill_store();
          send_req(cmd_t'($urandom_range(3, 1)), 8'($urandom), 7'($urandom));
        end else begin
          // loose requests of any kind
          repeat ($urandom_range(3, 1))
            send_req(cmd_t'($urandom_range(3)), 8'($urandom),
                     ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(8)));
        end
      end
    end

    // drain, then wait on to catch anything extra
    go_quiet();
    for (k = 0; k < DRAIN_LIMIT && pending != 0; k++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

/* byte_ring_with_mark_search.f */
rtl/core/brms_pkg.sv
rtl/core/brms_ram.sv
rtl/core/byte_ring_with_mark_search.sv
rtl/core/brms_checker.sv
tb/sv/brms_result_check.sv
tb/sv/tb_byte_ring_with_mark_search.sv
